### rtl/hsl_to_rgb_tone_pixel_assert.svh
// Assertion macros for the HSL toner RTL.
`ifndef HSL_TO_RGB_TONE_PIXEL_ASSERT_SVH
`define HSL_TO_RGB_TONE_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/htr_pkg.sv
// Package with the types, constants and helpers of the HSL toner.
`default_nettype none

package htr_pkg;

  localparam int ADDR_W = 4;

  localparam logic [12:0] ONE_Q12     = 13'd4096;
  localparam logic [12:0] GREY_LIMIT  = 13'd16;
  localparam logic [11:0] HUE_THIRD   = 12'd1365;
  localparam logic [11:0] HUE_NTHIRD  = 12'd2731;
  localparam logic [11:0] HUE_HALF    = 12'd2048;
  localparam logic [11:0] HUE_TWO_3RD = 12'd2731;
  localparam logic [12:0] L_HALF      = 13'd2048;

  // Matrix weights in thousandths; the denominator is 1000 * 4096.
  localparam logic [21:0] MAT_DEN = 22'd4096000;
  localparam int LUMA_R = 213;
  localparam int LUMA_G = 715;
  localparam int LUMA_B = 72;
  localparam int KEEP_R = 787;
  localparam int KEEP_G = 285;
  localparam int KEEP_B = 928;
  localparam int MAT_SCALE = 125;

  // Final scaling: full scale is 125 * 2^39, half of it is the rounding bias.
  localparam logic signed [49:0] FIN_DEN  = 50'sd68719476736000;
  localparam logic [54:0]        FIN_BIAS = 55'd34359738368000;
  localparam logic [15:0]        RECIP_125 = 16'd33555;

  typedef enum logic [1:0] {
    REG_TINT_RED   = 2'd0,
    REG_TINT_GREEN = 2'd1,
    REG_TINT_BLUE  = 2'd2,
    REG_GRAY       = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [11:0] hue;
    logic [12:0] saturation;
    logic [12:0] lightness;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_out_t;

  typedef logic [24:0] q24_t;

  typedef struct packed {
    logic valid;
    q24_t r;
    q24_t g;
    q24_t b;
  } rgb_word_t;

  typedef struct packed {
    logic [21:0]        diag_r;
    logic [21:0]        diag_g;
    logic [21:0]        diag_b;
    logic [21:0]        w_r;
    logic [21:0]        w_g;
    logic [21:0]        w_b;
    logic signed [20:0] tint_r;
    logic signed [20:0] tint_g;
    logic signed [20:0] tint_b;
  } tone_coef_t;

  typedef struct packed {
    logic               valid;
    logic signed [49:0] num_r;
    logic signed [49:0] num_g;
    logic signed [49:0] num_b;
  } sum_word_t;

  function automatic logic [12:0] sat_unit(input logic [12:0] x);
    return (x > ONE_Q12) ? ONE_Q12 : x;
  endfunction

endpackage

`default_nettype wire

### rtl/hsl_to_rgb_tone_pixel.sv
// Top level of the HSL to RGB pixel toner with its register port.
//
//   channel  direction  handshake                     word
//   pixel    in         pixel_valid / pixel_ready     hue, saturation, lightness
//   rgb      out        rgb_valid / rgb_ready         red, green, blue
//   config   in         psel, penable, pwrite, pready tint_red .. gray_amount
//
// One word enters per clock unless the output stalls; its rgb_valid rises after the word passes
// the eight register stages of the datapath (four HSL, two matrix, two finish).
// The whole pipeline advances together: a stalled output word holds every stage.
// Reset clears the configuration registers and all stage valid bits; there is no other start-up.
`default_nettype none

module hsl_to_rgb_tone_pixel (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pixel_valid,
  output logic                              pixel_ready,
  input  wire htr_pkg::pixel_in_t           pixel,
  output logic                              rgb_valid,
  input  wire logic                         rgb_ready,
  output htr_pkg::pixel_out_t               rgb,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [htr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration registers.
  logic [13:0] tint_red, tint_green, tint_blue;
  logic [12:0] gray_amount;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint_red    <= 14'd0;
      tint_green  <= 14'd0;
      tint_blue   <= 14'd0;
      gray_amount <= 13'd0;
    end else if (cfg_write) begin
      unique case (htr_pkg::reg_index_t'(paddr[3:2]))
        htr_pkg::REG_TINT_RED:   tint_red    <= pwdata[13:0];
        htr_pkg::REG_TINT_GREEN: tint_green  <= pwdata[13:0];
        htr_pkg::REG_TINT_BLUE:  tint_blue   <= pwdata[13:0];
        htr_pkg::REG_GRAY:       gray_amount <= htr_pkg::sat_unit(pwdata[12:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (htr_pkg::reg_index_t'(paddr[3:2]))
      htr_pkg::REG_TINT_RED:   prdata = {{18{tint_red[13]}}, tint_red};
      htr_pkg::REG_TINT_GREEN: prdata = {{18{tint_green[13]}}, tint_green};
      htr_pkg::REG_TINT_BLUE:  prdata = {{18{tint_blue[13]}}, tint_blue};
      htr_pkg::REG_GRAY:       prdata = {19'd0, gray_amount};
      default:                 prdata = 32'd0;
    endcase
  end

  // Matrix coefficients follow the registers in the next cycle; the user must change the
  // registers only while no word is in flight; the block itself does not enforce it.
  htr_pkg::tone_coef_t coef, coef_next;
  logic [22:0] gy;
  assign gy = 23'(gray_amount);

  always_comb begin
    coef_next.diag_r = 22'(23'(htr_pkg::MAT_DEN) - gy * 23'(htr_pkg::KEEP_R));
    coef_next.diag_g = 22'(23'(htr_pkg::MAT_DEN) - gy * 23'(htr_pkg::KEEP_G));
    coef_next.diag_b = 22'(23'(htr_pkg::MAT_DEN) - gy * 23'(htr_pkg::KEEP_B));
    coef_next.w_r    = 22'(gy * 23'(htr_pkg::LUMA_R));
    coef_next.w_g    = 22'(gy * 23'(htr_pkg::LUMA_G));
    coef_next.w_b    = 22'(gy * 23'(htr_pkg::LUMA_B));
    coef_next.tint_r = $signed({{7{tint_red[13]}}, tint_red})
                       * $signed(21'(htr_pkg::MAT_SCALE));
    coef_next.tint_g = $signed({{7{tint_green[13]}}, tint_green})
                       * $signed(21'(htr_pkg::MAT_SCALE));
    coef_next.tint_b = $signed({{7{tint_blue[13]}}, tint_blue})
                       * $signed(21'(htr_pkg::MAT_SCALE));
  end

  always_ff @(posedge clk) begin
    coef <= coef_next;
  end

  // Pipeline advance: move whenever the output register is empty or being taken.
  logic advance;
  assign advance     = !rgb_valid || rgb_ready;
  assign pixel_ready = advance;

  htr_pkg::rgb_word_t rgb_q24;
  htr_pkg::sum_word_t sum;

  htr_hsl u_hsl (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (pixel_valid),
    .pixel    (pixel),
    .rgb      (rgb_q24)
  );

  htr_matrix u_matrix (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .rgb  (rgb_q24),
    .coef (coef),
    .sum  (sum)
  );

  htr_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .sum       (sum),
    .out_valid (rgb_valid),
    .out_pixel (rgb)
  );

  logic gray_write, gray_ok, out_stall;
  assign gray_write = cfg_write && (paddr[3:2] == htr_pkg::REG_GRAY);
  assign gray_ok    = gray_amount <= htr_pkg::ONE_Q12;
  assign out_stall  = rgb_valid && !rgb_ready;

`include "hsl_to_rgb_tone_pixel_assert.svh"

  `HTR_ASSERT_NEXT(a_gray_max, clk, rst, gray_write, gray_ok, "gray amount above unity")
  `HTR_ASSERT_NOW(a_stall_hold, clk, rst, out_stall, !pixel_ready, "intake open while stalled")
  `HTR_ASSERT_NOW(a_rise, clk, rst, $rose(rgb_valid), $past(pixel_ready), "rose without advance")

endmodule

`default_nettype wire

### rtl/htr_hsl.sv
// HSL to RGB conversion in four register stages, channels in Q24.
`default_nettype none

module htr_hsl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire htr_pkg::pixel_in_t pixel,
  output htr_pkg::rgb_word_t     rgb
);

  // Interpolation weight in Q12 for one channel's hue position.
  function automatic logic [12:0] hue_ramp(input logic [11:0] h);
    logic [14:0] h6;
    h6 = (15'(h) << 2) + (15'(h) << 1);
    priority if (h6 < 15'd4096) begin
      return h6[12:0];
    end else if (h < htr_pkg::HUE_HALF) begin
      return htr_pkg::ONE_Q12;
    end else if (h < htr_pkg::HUE_TWO_3RD) begin
      return 13'(15'd16384 - h6);
    end else begin
      return 13'd0;
    end
  endfunction

  // Stage 1: clamp inputs, product l*s, hue weights.
  logic        s1_valid;
  logic        s1_grey;
  logic [12:0] s1_l;
  logic [12:0] s1_s;
  logic [25:0] s1_ls;
  logic [12:0] s1_kr, s1_kg, s1_kb;

  logic [12:0] sat_s, sat_l;
  assign sat_s = htr_pkg::sat_unit(pixel.saturation);
  assign sat_l = htr_pkg::sat_unit(pixel.lightness);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_grey <= (sat_s < htr_pkg::GREY_LIMIT);
      s1_l    <= sat_l;
      s1_s    <= sat_s;
      s1_ls   <= 26'(sat_l) * 26'(sat_s);
      s1_kr   <= hue_ramp(pixel.hue + htr_pkg::HUE_THIRD);
      s1_kg   <= hue_ramp(pixel.hue);
      s1_kb   <= hue_ramp(pixel.hue + htr_pkg::HUE_NTHIRD);
    end
  end

  // Stage 2: the two HSL levels v1 and v2, kept as v1 and v2 - v1.
  logic        s2_valid;
  logic        s2_grey;
  logic [12:0] s2_l;
  logic [24:0] s2_v1;
  logic [24:0] s2_diff;
  logic [12:0] s2_kr, s2_kg, s2_kb;

  logic [26:0] v2, l13, v1_next, diff_next;
  assign l13 = 27'(s1_l) << 13;
  always_comb begin
    if (s1_l < htr_pkg::L_HALF) begin
      v2 = (27'(s1_l) << 12) + 27'(s1_ls);
    end else begin
      v2 = ((27'(s1_l) + 27'(s1_s)) << 12) - 27'(s1_ls);
    end
    v1_next   = l13 - v2;
    diff_next = (v2 << 1) - l13;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_grey <= s1_grey;
      s2_l    <= s1_l;
      s2_v1   <= v1_next[24:0];
      s2_diff <= diff_next[24:0];
      s2_kr   <= s1_kr;
      s2_kg   <= s1_kg;
      s2_kb   <= s1_kb;
    end
  end

  // Stage 3: weighted span per channel.
  logic        s3_valid;
  logic        s3_grey;
  logic [12:0] s3_l;
  logic [24:0] s3_v1;
  logic [37:0] s3_pr, s3_pg, s3_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_grey <= s2_grey;
      s3_l    <= s2_l;
      s3_v1   <= s2_v1;
      s3_pr   <= 38'(s2_diff) * 38'(s2_kr);
      s3_pg   <= 38'(s2_diff) * 38'(s2_kg);
      s3_pb   <= 38'(s2_diff) * 38'(s2_kb);
    end
  end

  // Stage 4: round from Q36 to Q24, or take the lightness for a grey pixel.
  logic [37:0] base36;
  logic [37:0] cr, cg, cb;
  logic [24:0] grey24;
  assign base36 = (38'(s3_v1) << 12) + 38'd2048;
  assign cr     = (base36 + s3_pr) >> 12;
  assign cg     = (base36 + s3_pg) >> 12;
  assign cb     = (base36 + s3_pb) >> 12;
  assign grey24 = 25'(s3_l) << 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (en) begin
      rgb.valid <= s3_valid;
    end
    if (en) begin
      rgb.r <= s3_grey ? grey24 : cr[24:0];
      rgb.g <= s3_grey ? grey24 : cg[24:0];
      rgb.b <= s3_grey ? grey24 : cb[24:0];
    end
  end

endmodule

`default_nettype wire

### rtl/htr_matrix.sv
// Saturation matrix and tint in two register stages.
`default_nettype none

module htr_matrix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire htr_pkg::rgb_word_t  rgb,
  input  wire htr_pkg::tone_coef_t coef,
  output htr_pkg::sum_word_t      sum
);

  // Stage 5: nine coefficient products.
  logic        p_valid;
  logic [46:0] p_rr, p_rg, p_rb;
  logic [46:0] p_gr, p_gg, p_gb;
  logic [46:0] p_br, p_bg, p_bb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= rgb.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr <= 47'(coef.diag_r) * 47'(rgb.r);
      p_rg <= 47'(coef.w_g)    * 47'(rgb.g);
      p_rb <= 47'(coef.w_b)    * 47'(rgb.b);
      p_gr <= 47'(coef.w_r)    * 47'(rgb.r);
      p_gg <= 47'(coef.diag_g) * 47'(rgb.g);
      p_gb <= 47'(coef.w_b)    * 47'(rgb.b);
      p_br <= 47'(coef.w_r)    * 47'(rgb.r);
      p_bg <= 47'(coef.w_g)    * 47'(rgb.g);
      p_bb <= 47'(coef.diag_b) * 47'(rgb.b);
    end
  end

  // Stage 6: row sums plus the tint, which is scaled to the same full scale.
  logic [47:0] row_r, row_g, row_b;
  logic signed [49:0] tr, tg, tb;
  assign row_r = 48'(p_rr) + 48'(p_rg) + 48'(p_rb);
  assign row_g = 48'(p_gr) + 48'(p_gg) + 48'(p_gb);
  assign row_b = 48'(p_br) + 48'(p_bg) + 48'(p_bb);
  assign tr = $signed({{2{coef.tint_r[20]}}, coef.tint_r, 27'd0});
  assign tg = $signed({{2{coef.tint_g[20]}}, coef.tint_g, 27'd0});
  assign tb = $signed({{2{coef.tint_b[20]}}, coef.tint_b, 27'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      sum.valid <= 1'b0;
    end else if (en) begin
      sum.valid <= p_valid;
    end
    if (en) begin
      sum.num_r <= $signed({2'b00, row_r}) + tr;
      sum.num_g <= $signed({2'b00, row_g}) + tg;
      sum.num_b <= $signed({2'b00, row_b}) + tb;
    end
  end

endmodule

`default_nettype wire

### rtl/htr_finish.sv
// Clamp, scale by 255 and round, in two register stages.
`default_nettype none

module htr_finish (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire htr_pkg::sum_word_t sum,
  output logic                   out_valid,
  output htr_pkg::pixel_out_t    out_pixel
);

  // Numerator scaled by 255 plus half scale, divided by 2^39; the rest of the
  // division by 125 follows in the next stage.
  function automatic logic [14:0] coarse(input logic signed [49:0] num);
    logic [54:0] x;
    x = (55'(num[45:0]) << 8) - 55'(num[45:0]) + htr_pkg::FIN_BIAS;
    return x[53:39];
  endfunction

  logic        c_valid;
  logic [2:0]  c_low, c_high;
  logic [14:0] c_yr, c_yg, c_yb;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= sum.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_low  <= {sum.num_r <= 50'sd0, sum.num_g <= 50'sd0, sum.num_b <= 50'sd0};
      c_high <= {sum.num_r >= htr_pkg::FIN_DEN, sum.num_g >= htr_pkg::FIN_DEN,
                 sum.num_b >= htr_pkg::FIN_DEN};
      c_yr   <= coarse(sum.num_r);
      c_yg   <= coarse(sum.num_g);
      c_yb   <= coarse(sum.num_b);
    end
  end

  // Division by 125 as a multiply by a rounded-up reciprocal; exact below 2^15.
  function automatic logic [7:0] pick(input logic low, input logic high,
                                      input logic [14:0] y);
    logic [30:0] prod;
    prod = 31'(y) * 31'(htr_pkg::RECIP_125);
    priority if (low) begin
      return 8'd0;
    end else if (high) begin
      return 8'd255;
    end else begin
      return prod[29:22];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel.red   <= pick(c_low[2], c_high[2], c_yr);
      out_pixel.green <= pick(c_low[1], c_high[1], c_yg);
      out_pixel.blue  <= pick(c_low[0], c_high[0], c_yb);
    end
  end

endmodule

`default_nettype wire
